>>> sv/slfa_pkg.sv
// Shared types and constants for the serial line assembler with line queue.
`default_nettype none

package slfa_pkg;

    // Default sizes: bytes per line slot and lines held in the queue
    localparam int unsigned LINE_BYTES_DEF  = 64;
    localparam int unsigned QUEUE_LINES_DEF = 16;

    // Control characters
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // Width of the command argument field (covers the largest line size)
    localparam int unsigned ARG_W = 8;

    // Entries in the command queue between front and back
    localparam int unsigned CMD_FIFO_DEPTH = 2;

    typedef enum logic [3:0] {
        ST_CR        = 4'd0,
        ST_STORED    = 4'd1,
        ST_QUEUED    = 4'd2,
        ST_EMPTY_NL  = 4'd3,
        ST_QFULL     = 4'd4,
        ST_TOO_LONG  = 4'd5,
        ST_NULL_LINE = 4'd6,
        ST_CHAR      = 4'd7,
        ST_POP_NONE  = 4'd8,
        ST_POP_FAIL  = 4'd9
    } slfa_status_t;

    typedef enum logic [2:0] {
        CMD_CR        = 3'd0,
        CMD_STORE     = 3'd1,
        CMD_TOO_LONG  = 3'd2,
        CMD_EMPTY_NL  = 3'd3,
        CMD_NULL_LINE = 3'd4,
        CMD_FINISH    = 3'd5,
        CMD_POP       = 3'd6
    } slfa_cmd_kind_t;

    // Classified item: STORE carries position and byte, FINISH the kept
    // length, POP the capacity minus one and a no-capacity flag.
    typedef struct packed {
        slfa_cmd_kind_t   kind;
        logic [7:0]       data;
        logic [ARG_W-1:0] arg;
        logic             nocap;
    } slfa_cmd_t;

endpackage

`default_nettype wire

>>> sv/slfa_in_if.sv
// Input channel: received byte or pop request with valid/ready handshake.
`default_nettype none

interface slfa_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] rx_byte;
    logic [6:0] out_capacity;

    modport source (output valid, output mode, output rx_byte, output out_capacity,
                    input ready);
    modport sink   (input valid, input mode, input rx_byte, input out_capacity,
                    output ready);
endinterface

`default_nettype wire

>>> sv/slfa_out_if.sv
// Output channel: one result item with status, character and counters.
`default_nettype none

interface slfa_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  status;
    logic [7:0]  line_char;
    logic        last;
    logic        line_complete;
    logic [4:0]  pending_lines;
    logic [31:0] dropped_total;
    logic [31:0] received_total;
    logic [4:0]  peak_depth;

    modport source (output valid, output status, output line_char, output last,
                    output line_complete, output pending_lines, output dropped_total,
                    output received_total, output peak_depth, input ready);
    modport sink   (input valid, input status, input line_char, input last,
                    input line_complete, input pending_lines, input dropped_total,
                    input received_total, input peak_depth, output ready);
endinterface

`default_nettype wire

>>> sv/slfa_cmd_fifo.sv
// Short command queue between the classifying front and the executing back.
`default_nettype none

module slfa_cmd_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  slfa_pkg::slfa_cmd_t push_data,
    output logic               pop_valid,
    input  logic               pop_ready,
    output slfa_pkg::slfa_cmd_t pop_data
);
    import slfa_pkg::*;

    localparam int unsigned DEPTH = CMD_FIFO_DEPTH;
    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    slfa_cmd_t        entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg < CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> sv/slfa_front.sv
// Front: accept items, track the line being built and classify each item.
`default_nettype none

module slfa_front #(
    parameter int unsigned LINE_BYTES = slfa_pkg::LINE_BYTES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    slfa_in_if.sink             req,
    output logic                push_valid,
    input  logic                push_ready,
    output slfa_pkg::slfa_cmd_t push_cmd
);
    import slfa_pkg::*;

    localparam int unsigned POS_W = $clog2(LINE_BYTES);
    localparam int unsigned CAP_W = ($clog2(LINE_BYTES + 1) > 7) ?
                                    $clog2(LINE_BYTES + 1) : 7;

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] vlen_reg, vlen_next;   // length up to the first zero byte
    logic             zseen_reg, zseen_next;
    logic             accept;
    logic [CAP_W-1:0] cap_ext, cap_clamp, cap_m1;

    assign req.ready  = push_ready;
    assign push_valid = req.valid;
    assign accept     = req.valid && push_ready;

    assign cap_ext   = CAP_W'(req.out_capacity);
    assign cap_clamp = (cap_ext > CAP_W'(LINE_BYTES)) ? CAP_W'(LINE_BYTES) : cap_ext;
    assign cap_m1    = cap_clamp - 1'b1;

    always_comb
    begin
        pos_next       = pos_reg;
        vlen_next      = vlen_reg;
        zseen_next     = zseen_reg;
        push_cmd.kind  = CMD_CR;
        push_cmd.data  = req.rx_byte;
        push_cmd.arg   = '0;
        push_cmd.nocap = (req.out_capacity == '0);
        if (req.mode)
        begin
            push_cmd.kind = CMD_POP;
            push_cmd.arg  = ARG_W'(POS_W'(cap_m1));
        end
        else if (req.rx_byte == CHAR_CR)
        begin
            push_cmd.kind = CMD_CR;
        end
        else if (req.rx_byte == CHAR_LF)
        begin
            if (pos_reg == '0)
            begin
                push_cmd.kind = CMD_EMPTY_NL;
            end
            else if (vlen_reg == '0)
            begin
                push_cmd.kind = CMD_NULL_LINE;
            end
            else
            begin
                push_cmd.kind = CMD_FINISH;
                push_cmd.arg  = ARG_W'(vlen_reg);
            end
            pos_next   = '0;
            vlen_next  = '0;
            zseen_next = 1'b0;
        end
        else if (pos_reg < POS_W'(LINE_BYTES - 1))
        begin
            push_cmd.kind = CMD_STORE;
            push_cmd.arg  = ARG_W'(pos_reg);
            pos_next      = pos_reg + 1'b1;
            if (!zseen_reg)
            begin
                if (req.rx_byte == 8'h00)
                begin
                    zseen_next = 1'b1;
                end
                else
                begin
                    vlen_next = vlen_reg + 1'b1;
                end
            end
        end
        else
        begin
            // Line overruns its slot: drop it and start over
            push_cmd.kind = CMD_TOO_LONG;
            pos_next      = '0;
            vlen_next     = '0;
            zseen_next    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            vlen_reg  <= '0;
            zseen_reg <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            vlen_reg  <= vlen_next;
            zseen_reg <= zseen_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/slfa_back.sv
// Back: execute commands against the line store, counters and result register.
`default_nettype none

module slfa_back #(
    parameter int unsigned LINE_BYTES  = slfa_pkg::LINE_BYTES_DEF,
    parameter int unsigned QUEUE_LINES = slfa_pkg::QUEUE_LINES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  slfa_pkg::slfa_cmd_t pop_cmd,
    slfa_out_if.source          rsp
);
    import slfa_pkg::*;

    localparam int unsigned SLOTS     = QUEUE_LINES + 1;
    localparam int unsigned SLOT_W    = $clog2(SLOTS);
    localparam int unsigned MEM_DEPTH = SLOTS * LINE_BYTES;
    localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);
    localparam int unsigned POS_W     = $clog2(LINE_BYTES);
    localparam int unsigned CNT_W     = $clog2(QUEUE_LINES + 1);
    localparam int unsigned LAST_BASE = (SLOTS - 1) * LINE_BYTES;

    typedef enum logic [2:0] {
        S_IDLE    = 3'b001,
        S_POP_LEN = 3'b010,
        S_CHARS   = 3'b100
    } slfa_back_state_t;

    typedef struct packed {
        slfa_status_t status;
        logic [7:0]   line_char;
        logic         last;
        logic         line_complete;
        logic [4:0]   pending_lines;
        logic [31:0]  dropped_total;
        logic [31:0]  received_total;
        logic [4:0]   peak_depth;
    } slfa_result_t;

    slfa_back_state_t  state_reg, state_next;
    logic [SLOT_W-1:0] head_slot_reg, head_slot_next;
    logic [SLOT_W-1:0] tail_slot_reg, tail_slot_next;
    logic [ADDR_W-1:0] head_base_reg, head_base_next;
    logic [ADDR_W-1:0] tail_base_reg, tail_base_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  hw_reg, hw_next;
    logic [31:0]       drop_reg, drop_next;
    logic [31:0]       acc_reg, acc_next;
    logic [POS_W-1:0]  capm1_reg, capm1_next;
    logic [POS_W-1:0]  remain_reg, remain_next;
    logic [ADDR_W-1:0] char_addr_reg, char_addr_next;
    logic              out_valid_reg, out_valid_next;
    slfa_result_t      out_reg, out_next;

    logic [7:0]        line_mem [MEM_DEPTH];
    logic [POS_W-1:0]  len_mem  [SLOTS];
    logic [7:0]        rd_char_q;
    logic [POS_W-1:0]  len_q;

    logic              out_free, emit;
    logic              line_we, len_we;
    logic [ADDR_W-1:0] line_waddr;
    logic [POS_W-1:0]  cmd_arg, keep;
    slfa_status_t      emit_status;
    logic [7:0]        emit_char;
    logic              emit_last, emit_complete;

    assign out_free = !out_valid_reg || rsp.ready;
    assign cmd_arg  = POS_W'(pop_cmd.arg);
    assign keep     = (len_q < capm1_reg) ? len_q : capm1_reg;

    always_comb
    begin
        state_next     = state_reg;
        head_slot_next = head_slot_reg;
        tail_slot_next = tail_slot_reg;
        head_base_next = head_base_reg;
        tail_base_next = tail_base_reg;
        count_next     = count_reg;
        hw_next        = hw_reg;
        drop_next      = drop_reg;
        acc_next       = acc_reg;
        capm1_next     = capm1_reg;
        remain_next    = remain_reg;
        char_addr_next = char_addr_reg;
        pop_ready      = 1'b0;
        emit           = 1'b0;
        emit_status    = ST_CR;
        emit_char      = 8'h00;
        emit_last      = 1'b1;
        emit_complete  = 1'b0;
        line_we        = 1'b0;
        len_we         = 1'b0;
        line_waddr     = tail_base_reg + ADDR_W'(cmd_arg);

        case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop_ready = 1'b1;
                    case (pop_cmd.kind)
                        CMD_CR:
                        begin
                            emit        = 1'b1;
                            emit_status = ST_CR;
                        end
                        CMD_STORE:
                        begin
                            line_we     = 1'b1;
                            emit        = 1'b1;
                            emit_status = ST_STORED;
                        end
                        CMD_TOO_LONG:
                        begin
                            drop_next   = drop_reg + 32'd1;
                            emit        = 1'b1;
                            emit_status = ST_TOO_LONG;
                        end
                        CMD_EMPTY_NL:
                        begin
                            emit          = 1'b1;
                            emit_status   = ST_EMPTY_NL;
                            emit_complete = 1'b1;
                        end
                        CMD_NULL_LINE:
                        begin
                            emit          = 1'b1;
                            emit_status   = ST_NULL_LINE;
                            emit_complete = 1'b1;
                        end
                        CMD_FINISH:
                        begin
                            emit          = 1'b1;
                            emit_complete = 1'b1;
                            if (count_reg >= CNT_W'(QUEUE_LINES))
                            begin
                                drop_next   = drop_reg + 32'd1;
                                emit_status = ST_QFULL;
                            end
                            else
                            begin
                                len_we         = 1'b1;
                                tail_slot_next = (tail_slot_reg == SLOT_W'(SLOTS - 1)) ?
                                                 '0 : tail_slot_reg + 1'b1;
                                tail_base_next = (tail_base_reg == ADDR_W'(LAST_BASE)) ?
                                                 '0 : tail_base_reg + ADDR_W'(LINE_BYTES);
                                count_next     = count_reg + 1'b1;
                                acc_next       = acc_reg + 32'd1;
                                if (count_next > hw_reg)
                                begin
                                    hw_next = count_next;
                                end
                                emit_status    = ST_QUEUED;
                            end
                        end
                        CMD_POP:
                        begin
                            if (pop_cmd.nocap || count_reg == '0)
                            begin
                                emit        = 1'b1;
                                emit_status = ST_POP_FAIL;
                            end
                            else
                            begin
                                capm1_next = cmd_arg;
                                state_next = S_POP_LEN;
                            end
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end

            S_POP_LEN:
            begin
                // Point the character read at the head slot while the length settles
                char_addr_next = head_base_reg;
                if (out_free)
                begin
                    head_slot_next = (head_slot_reg == SLOT_W'(SLOTS - 1)) ?
                                     '0 : head_slot_reg + 1'b1;
                    head_base_next = (head_base_reg == ADDR_W'(LAST_BASE)) ?
                                     '0 : head_base_reg + ADDR_W'(LINE_BYTES);
                    count_next     = count_reg - 1'b1;
                    if (keep == '0)
                    begin
                        emit        = 1'b1;
                        emit_status = ST_POP_NONE;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        remain_next = keep;
                        state_next  = S_CHARS;
                    end
                end
            end

            S_CHARS:
            begin
                if (out_free)
                begin
                    emit           = 1'b1;
                    emit_status    = ST_CHAR;
                    emit_char      = rd_char_q;
                    emit_last      = (remain_reg == POS_W'(1));
                    char_addr_next = char_addr_reg + 1'b1;
                    remain_next    = remain_reg - 1'b1;
                    if (remain_reg == POS_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_next                = out_reg;
        out_valid_next          = out_valid_reg && !rsp.ready;
        if (emit)
        begin
            out_valid_next          = 1'b1;
            out_next.status         = emit_status;
            out_next.line_char      = emit_char;
            out_next.last           = emit_last;
            out_next.line_complete  = emit_complete;
            out_next.pending_lines  = 5'(count_next);
            out_next.dropped_total  = drop_next;
            out_next.received_total = acc_next;
            out_next.peak_depth     = 5'(hw_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_slot_reg <= '0;
            tail_slot_reg <= '0;
            head_base_reg <= '0;
            tail_base_reg <= '0;
            count_reg     <= '0;
            hw_reg        <= '0;
            drop_reg      <= '0;
            acc_reg       <= '0;
            remain_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_slot_reg <= head_slot_next;
            tail_slot_reg <= tail_slot_next;
            head_base_reg <= head_base_next;
            tail_base_reg <= tail_base_next;
            count_reg     <= count_next;
            hw_reg        <= hw_next;
            drop_reg      <= drop_next;
            acc_reg       <= acc_next;
            remain_reg    <= remain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        capm1_reg     <= capm1_next;
        char_addr_reg <= char_addr_next;
        out_reg       <= out_next;
    end

    // Line store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (line_we)
        begin
            line_mem[line_waddr] <= pop_cmd.data;
        end
        rd_char_q <= line_mem[char_addr_next];
    end

    // Length table: written at the tail slot, read at the head slot
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[tail_slot_reg] <= cmd_arg;
        end
        len_q <= len_mem[head_slot_reg];
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.line_char      = out_reg.line_char;
    assign rsp.last           = out_reg.last;
    assign rsp.line_complete  = out_reg.line_complete;
    assign rsp.pending_lines  = out_reg.pending_lines;
    assign rsp.dropped_total  = out_reg.dropped_total;
    assign rsp.received_total = out_reg.received_total;
    assign rsp.peak_depth     = out_reg.peak_depth;

endmodule

`default_nettype wire

>>> sv/serial_line_assembler_fifo_unit.sv
// Top level of the serial line assembler with a queue of completed lines.
`default_nettype none

// Serial line assembler: each item on req is either a received byte
// (mode 0) or a request to pop the oldest completed line (mode 1). Bytes
// build a line, carriage returns are ignored, and a newline queues the line
// (cut at its first zero byte) into a queue of QUEUE_LINES lines of up to
// LINE_BYTES-1 characters. Every received byte gives one result item on rsp;
// a pop gives one result per kept character (last marks the final one), or a
// single status result when nothing is kept or the pop fails. Each result
// carries the queue depth, the wrapping drop and accept counts and the peak
// depth as they stand after that item. Bytes stream at one per cycle while
// rsp is ready and no pop is streaming. A successful pop reads the line
// length from the length table, then gives one character per cycle while
// rsp is ready, paced by the registered read port of the line store. A
// two-entry command queue sits between the front, which tracks the line
// under construction, and the back, which owns the store and counters, so the
// front takes items until the queue fills while the back streams or stalls.
// No clearing pass is needed after reset; the block is ready at once.

module serial_line_assembler_fifo_unit #(
    parameter int unsigned LINE_BYTES  = slfa_pkg::LINE_BYTES_DEF,
    parameter int unsigned QUEUE_LINES = slfa_pkg::QUEUE_LINES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    slfa_in_if.sink    req,
    slfa_out_if.source rsp
);
    import slfa_pkg::*;

    // Front to queue
    logic      push_valid;
    logic      push_ready;
    slfa_cmd_t push_cmd;

    // Queue to back
    logic      pop_valid;
    logic      pop_ready;
    slfa_cmd_t pop_cmd;

    // Classify items and hold the line-building position
    slfa_front #(
        .LINE_BYTES (LINE_BYTES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // Decouple front and back so either side can stall alone
    slfa_cmd_fifo u_cmd_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    // Store lines, advance the queue, update counters and drive results
    slfa_back #(
        .LINE_BYTES  (LINE_BYTES),
        .QUEUE_LINES (QUEUE_LINES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_cmd   (pop_cmd),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
